@@ hw/rtl/double_word_divide_defines.svh @@
// Assertion macros for the double-word divider checker.
// Depends on nothing; included by the checker file.
`ifndef DOUBLE_WORD_DIVIDE_DEFINES_SVH
`define DOUBLE_WORD_DIVIDE_DEFINES_SVH

// same-cycle implication
`define DWD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DWD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/dwd_pkg.sv @@
// Shared types and constants for the double-word divider.
// No dependencies.
package dwd_pkg;
	localparam int WORD_BITS  = 64;
	localparam int FIELD_BITS = 64;
	localparam int STEPS      = 2 * WORD_BITS;

	typedef logic [WORD_BITS-1:0]   word_t;
	typedef logic [2*WORD_BITS-1:0] dword_t;
	typedef logic [FIELD_BITS-1:0]  field_t;

	typedef struct packed {
		word_t  rem;
		dword_t num;
		word_t  q;
		word_t  d;
	} dwd_work_t;
endpackage

@@ hw/rtl/dwd_prep.sv @@
// Input stage: mask the fields to the word width and reduce the high word once.
// Depends on dwd_pkg.
module dwd_prep (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_v,
	input  dwd_pkg::field_t   hi_in,
	input  dwd_pkg::field_t   lo_in,
	input  dwd_pkg::field_t   d_in,
	output logic              out_v,
	output dwd_pkg::dwd_work_t out_w
);
	import dwd_pkg::*;

	word_t     hi, lo, d, hi_red;
	logic      v_s1;
	dwd_work_t w_s1;

	assign hi     = hi_in[WORD_BITS-1:0];
	assign lo     = lo_in[WORD_BITS-1:0];
	assign d      = d_in[WORD_BITS-1:0];
	assign hi_red = (hi >= d) ? hi - d : hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	// zero divisor needs no special path: every step then sets its quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			w_s1.rem <= '0;
			w_s1.num <= {hi_red, lo};
			w_s1.q   <= '0;
			w_s1.d   <= d;
		end
	end

	assign out_v = v_s1;
	assign out_w = w_s1;
endmodule

@@ hw/rtl/dwd_stage.sv @@
// One restoring-division step: shift in a dividend bit, compare, subtract.
// Depends on dwd_pkg.
module dwd_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  dwd_pkg::dwd_work_t in_w,
	output logic               out_v,
	output dwd_pkg::dwd_work_t out_w
);
	import dwd_pkg::*;

	logic [WORD_BITS:0] shifted, diff;
	logic               ge;
	logic               v_s1;
	dwd_work_t          w_s1;

	assign shifted = {in_w.rem, in_w.num[2*WORD_BITS-1]};
	assign diff    = shifted - {1'b0, in_w.d};
	assign ge      = (shifted >= {1'b0, in_w.d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1.rem <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
			w_s1.num <= {in_w.num[2*WORD_BITS-2:0], 1'b0};
			w_s1.q   <= {in_w.q[WORD_BITS-2:0], ge};
			w_s1.d   <= in_w.d;
		end
	end

	assign out_v = v_s1;
	assign out_w = w_s1;
endmodule

@@ hw/rtl/dwd_out.sv @@
// Output register with a skid stage; generates the pipeline advance enable.
// Depends on dwd_pkg.
module dwd_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pipe_v,
	input  dwd_pkg::word_t  pipe_q,
	output logic            en,
	output logic            out_valid,
	input  logic            out_ready,
	output dwd_pkg::field_t quotient
);
	import dwd_pkg::*;

	logic  out_valid_q, skid_valid_q, take;
	word_t out_q, skid_q;

	assign en   = !skid_valid_q;
	assign take = en && pipe_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : pipe_q;
		end else if (take) begin
			skid_q <= pipe_q;
		end
	end

	assign out_valid = out_valid_q;
	assign quotient  = field_t'(out_q);
endmodule

@@ hw/rtl/double_word_divide.sv @@
// Double-word by single-word unsigned divider, one restoring step per stage.
// Pipeline: input stage, one stage per dividend bit, output register.
// Throughput: one beat per cycle; the whole pipeline holds while the output
// skid stage is full.
// Reset clears the valid bits and the output/skid flags only.
module double_word_divide (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dwd_pkg::field_t dividend_high,
	input  dwd_pkg::field_t dividend_low,
	input  dwd_pkg::field_t divisor,
	output logic            out_valid,
	input  logic            out_ready,
	output dwd_pkg::field_t quotient
);
	import dwd_pkg::*;

	logic      en;
	logic      v [STEPS+1];
	dwd_work_t w [STEPS+1];

	assign in_ready = en;

	dwd_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (in_valid),
		.hi_in  (dividend_high),
		.lo_in  (dividend_low),
		.d_in   (divisor),
		.out_v  (v[0]),
		.out_w  (w[0])
	);

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		dwd_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.in_v   (v[i]),
			.in_w   (w[i]),
			.out_v  (v[i+1]),
			.out_w  (w[i+1])
		);
	end

	dwd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.pipe_v    (v[STEPS]),
		.pipe_q    (w[STEPS].q),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.quotient  (quotient)
	);
endmodule

@@ hw/rtl/double_word_divide_chk.sv @@
// Port-level checker for the double-word divider, bound to the top level.
// Depends on dwd_pkg and double_word_divide_defines.svh.
`include "double_word_divide_defines.svh"

module double_word_divide_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input dwd_pkg::field_t quotient
);
	import dwd_pkg::*;

	`DWD_ASSERT_NEXT(a_out_hold, clk, arst_n,
		out_valid && !out_ready, out_valid && $stable(quotient),
		"output beat dropped or changed while stalled")
	`DWD_ASSERT_NOW(a_stall_needs_out, clk, arst_n,
		!in_ready, out_valid,
		"input stalled with empty output register")
	`DWD_ASSERT_NEXT(a_stall_cause, clk, arst_n,
		out_valid && out_ready, in_ready,
		"skid stage not drained after output beat")
	`DWD_ASSERT_NOW(a_stall_start, clk, arst_n,
		$fell(in_ready), $past(out_valid && !out_ready),
		"input stalled without output backpressure")
endmodule

bind double_word_divide double_word_divide_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.quotient  (quotient)
);

@@ sim/double_word_divide_checker.sv @@
// Beat monitor and quotient predictor for the double-word divider.
// Depends on dwd_pkg; instantiated beside the block by tb_double_word_divide.
`timescale 1ns / 100ps

module double_word_divide_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  dwd_pkg::field_t dividend_high,
	input  dwd_pkg::field_t dividend_low,
	input  dwd_pkg::field_t divisor,
	input  logic            out_valid,
	input  logic            out_ready,
	input  dwd_pkg::field_t quotient,
	output int unsigned     fail_count,
	output int unsigned     outstanding
);
	import dwd_pkg::*;

	typedef struct {
		word_t hi;
		word_t lo;
		word_t d;
		word_t q;
	} division_t;

	division_t pending_q[$];

	function automatic word_t quotient_of(word_t hi, word_t lo, word_t d);
		dword_t num;
		dword_t wide;
		if (d == '0)
			return '1;
		if (hi >= d)
			hi = hi - d;
		num  = {hi, lo};
		wide = num / {{WORD_BITS{1'b0}}, d};
		return wide[WORD_BITS-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		division_t div;
		if (!arst_n) begin
			pending_q.delete();
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: quotient beat with no division pending: actual %h",
						$time, quotient);
					fail_count <= fail_count + 1;
				end else begin
					div = pending_q.pop_front();
					if (quotient[WORD_BITS-1:0] !== div.q) begin
						$display("%0t: quotient mismatch for %h_%h / %h: expected %h, actual %h",
							$time, div.hi, div.lo, div.d, div.q, quotient);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				div.hi = dividend_high[WORD_BITS-1:0];
				div.lo = dividend_low[WORD_BITS-1:0];
				div.d  = divisor[WORD_BITS-1:0];
				div.q  = quotient_of(div.hi, div.lo, div.d);
				pending_q.push_back(div);
			end
			outstanding <= pending_q.size();
		end
	end
endmodule

@@ sim/tb_double_word_divide.sv @@
// Top of the double-word divider testbench: clock, reset, beat stimulus
// with random idling, verdict. Depends on dwd_pkg and double_word_divide_checker.
`timescale 1ns / 100ps

module tb_double_word_divide;
	import dwd_pkg::*;

	localparam word_t ALL_ONES = '1;
	localparam word_t TOP_BIT  = word_t'(1) << (WORD_BITS - 1);
	localparam int    RANDOM_BEATS = 1150;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	field_t      dividend_high = '0;
	field_t      dividend_low = '0;
	field_t      divisor = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	field_t      quotient;
	int unsigned fail_count;
	int unsigned outstanding;
	bit          calm_sender = 1'b0;

	double_word_divide dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.dividend_high(dividend_high),
		.dividend_low (dividend_low),
		.divisor      (divisor),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.quotient     (quotient)
	);

	double_word_divide_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.dividend_high(dividend_high),
		.dividend_low (dividend_low),
		.divisor      (divisor),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.quotient     (quotient),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 150);
	endfunction

	function automatic word_t rand_word();
		return word_t'({$urandom, $urandom});
	endfunction

	task automatic send_division(input word_t hi, input word_t lo, input word_t d);
		int gap;
		gap = calm_sender ? 0 : idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		dividend_high <= hi;
		dividend_low  <= lo;
		divisor       <= d;
		in_valid      <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// receiver: ready runs with random stalls, sometimes a long clean run
	initial begin
		int run;
		int stall;
		forever begin
			if ($urandom_range(0, 9) == 0)
				run = $urandom_range(100, 300);
			else
				run = $urandom_range(1, 20);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		word_t hi;
		word_t lo;
		word_t d;
		int    kind;
		int    shift;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero divisor
		send_division('0, '0, '0);
		send_division(ALL_ONES, ALL_ONES, '0);
		send_division('0, word_t'(12345), '0);
		// extremes
		send_division('0, ALL_ONES, word_t'(1));
		send_division('0, '0, ALL_ONES);
		send_division(ALL_ONES, ALL_ONES, ALL_ONES);
		send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES);
		send_division('0, ALL_ONES, ALL_ONES);
		// high word equal to the divisor
		send_division(word_t'(5), '0, word_t'(5));
		send_division(TOP_BIT, ALL_ONES, TOP_BIT);
		// high word at least twice the divisor: truncated quotient
		send_division(word_t'(10), word_t'(7), word_t'(5));
		send_division(ALL_ONES, '0, word_t'(1));
		send_division(ALL_ONES, ALL_ONES, word_t'(1));
		send_division(ALL_ONES, ALL_ONES, word_t'(3));
		// divisor with the top bit set, remainder carry path
		send_division(TOP_BIT, '0, TOP_BIT + 1);
		send_division(TOP_BIT - 1, ALL_ONES, TOP_BIT);
		send_division(ALL_ONES, ALL_ONES, TOP_BIT);
		send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES - 1);
		// small divisors
		send_division(word_t'(1), '0, word_t'(2));
		send_division('0, word_t'(1), word_t'(2));
		send_division(word_t'(2), ALL_ONES, word_t'(3));
		send_division({(WORD_BITS/2){2'b10}}, {(WORD_BITS/2){2'b01}}, word_t'(32'hffff_ffff));

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 64 == 0)
				calm_sender = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 99);
			hi   = rand_word();
			lo   = rand_word();
			d    = rand_word();
			if (kind < 30) begin
				// fully random
			end else if (kind < 60) begin
				// in-range quotient
				if (d == '0)
					d = word_t'(1);
				hi = hi % d;
			end else if (kind < 75) begin
				d = word_t'($urandom_range(1, 255)) << $urandom_range(0, WORD_BITS - 8);
				if ($urandom_range(0, 1) == 1)
					hi = hi % d;
			end else if (kind < 85) begin
				shift = $urandom_range(0, WORD_BITS - 1);
				d  = d >> shift;
				hi = hi >> $urandom_range(0, WORD_BITS - 1);
				lo = lo >> $urandom_range(0, WORD_BITS - 1);
			end else if (kind < 90) begin
				d = '0;
			end else if (kind < 95) begin
				hi = d + word_t'($urandom_range(0, 3));
			end else begin
				d = d | TOP_BIT;
				if ($urandom_range(0, 1) == 1)
					hi = d - 1;
			end
			send_division(hi, lo, d);
		end
		in_valid <= 1'b0;

		@(posedge clk);
		wait (outstanding == 0);
		repeat (2 * WORD_BITS + 20) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("Simulation FAILED");
		$finish;
	end
endmodule
